// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define LPB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lpb assertion failed");

// clocked check that also holds during reset
`define LPB_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("lpb assertion failed");

`endif

// ===== rtl/lpb_pkg.sv =====
// ----------------------------------------------------------------------------
// lpb_pkg
// Shared types, widths and field layout of the LRU page buffer pool.
// ----------------------------------------------------------------------------
package lpb_pkg;

    localparam int CAP_DEFAULT = 16;
    localparam int CFG_W       = 5;
    localparam int PAGE_W      = 32;
    localparam int PINS_W      = 8;
    localparam int FRAME_W     = 4;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 48;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    localparam logic ACT_FETCH = 1'b0;
    localparam logic ACT_UNPIN = 1'b1;

    // bit offsets of the result word
    localparam int OB_HIT    = 0;
    localparam int OB_FOUND  = 1;
    localparam int OB_FRAME  = 2;
    localparam int OB_EVICT  = 6;
    localparam int OB_EVPAGE = 7;
    localparam int OB_PINS   = 39;

    localparam int IB_PAGE  = 0;
    localparam int IB_DIRTY = 32;

    typedef struct packed {
        logic              action;
        logic [PAGE_W-1:0] page_id;
        logic              set_dirty;
    } lpb_req_t;

    typedef struct packed {
        logic               hit;
        logic               found;
        logic [FRAME_W-1:0] frame_index;
        logic               evicted;
        logic [PAGE_W-1:0]  evicted_page_id;
        logic [PINS_W-1:0]  pin_count;
    } lpb_rsp_t;

    function automatic logic [OUT_DATA_W-1:0] pack_rsp(lpb_rsp_t r);
        logic [OUT_DATA_W-1:0] w;
        w                               = '0;
        w[OB_HIT]                       = r.hit;
        w[OB_FOUND]                     = r.found;
        w[OB_FRAME +: FRAME_W]          = r.frame_index;
        w[OB_EVICT]                     = r.evicted;
        w[OB_EVPAGE +: PAGE_W]          = r.evicted_page_id;
        w[OB_PINS +: PINS_W]            = r.pin_count;
        return w;
    endfunction

endpackage

// ===== rtl/lpb_in_stage.sv =====
// ----------------------------------------------------------------------------
// lpb_in_stage
// Input register holding one request transaction until the table takes it.
// ----------------------------------------------------------------------------
module lpb_in_stage
    import lpb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  lpb_req_t req_in,
    input  logic     advance,
    output logic     req_valid,
    output lpb_req_t req_out
);

    logic     valid_reg;
    logic     valid_next;
    lpb_req_t req_reg;
    logic     load;

    assign s_tready   = !valid_reg || advance;
    assign load       = s_tvalid && s_tready;
    assign valid_next = load || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_reg <= req_in;
        end
    end

    assign req_valid = valid_reg;
    assign req_out   = req_reg;

endmodule

// ===== rtl/lpb_table.sv =====
// ----------------------------------------------------------------------------
// lpb_table
// Fully associative page table: parallel tag match, LRU ages, pin counts.
// ----------------------------------------------------------------------------
module lpb_table
    import lpb_pkg::*;
#(
    parameter int CAPACITY = CAP_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CFG_W-1:0] cap_cfg,
    input  logic             req_valid,
    input  lpb_req_t         req,
    output lpb_rsp_t         rsp
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int AGE_W = $clog2(CAPACITY);
    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;

    logic              valid_reg [CAPACITY];
    logic              valid_next[CAPACITY];
    logic [AGE_W-1:0]  age_reg   [CAPACITY];
    logic [AGE_W-1:0]  age_next  [CAPACITY];
    logic [PINS_W-1:0] pins_reg  [CAPACITY];
    logic [PINS_W-1:0] pins_next [CAPACITY];
    logic              dirty_reg [CAPACITY];
    logic              dirty_next[CAPACITY];
    logic [PAGE_W-1:0] page_reg  [CAPACITY];
    logic [OCC_W-1:0]  occ_reg;
    logic [OCC_W-1:0]  occ_next;

    logic              hit_any;
    logic [IDX_W-1:0]  hit_idx;
    logic [IDX_W-1:0]  victim_idx;
    logic [IDX_W-1:0]  free_idx;
    logic [IDX_W-1:0]  tgt_idx;
    logic [CMP_W-1:0]  cap_eff;
    logic              full;
    logic [AGE_W-1:0]  sel_age;
    logic [PINS_W-1:0] sel_pins;
    logic [PINS_W-1:0] pins_inc;
    logic [PINS_W-1:0] pins_dec;
    logic              is_fetch;
    logic              page_we;

    always_comb
    begin
        hit_any    = 1'b0;
        hit_idx    = '0;
        victim_idx = '0;
        free_idx   = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && page_reg[i] == req.page_id)
            begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (valid_reg[i] && (OCC_W'(age_reg[i]) + OCC_W'(1)) == occ_reg)
            begin
                victim_idx = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        if (cap_cfg == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (CMP_W'(cap_cfg) > CMP_W'(CAPACITY))
        begin
            cap_eff = CMP_W'(CAPACITY);
        end
        else
        begin
            cap_eff = CMP_W'(cap_cfg);
        end
    end

    assign full     = CMP_W'(occ_reg) >= cap_eff;
    assign tgt_idx  = full ? victim_idx : free_idx;
    assign sel_age  = age_reg[hit_idx];
    assign sel_pins = pins_reg[hit_idx];
    assign pins_inc = (sel_pins == '1) ? sel_pins : sel_pins + PINS_W'(1);
    assign pins_dec = (sel_pins == '0) ? sel_pins : sel_pins - PINS_W'(1);
    assign is_fetch = req.action == ACT_FETCH;
    assign page_we  = req_valid && is_fetch && !hit_any;

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            valid_next[i] = valid_reg[i];
            age_next[i]   = age_reg[i];
            pins_next[i]  = pins_reg[i];
            dirty_next[i] = dirty_reg[i];
        end
        occ_next = occ_reg;
        rsp      = '0;

        if (req_valid)
        begin
            if (is_fetch)
            begin
                if (hit_any)
                begin
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (valid_reg[i] && IDX_W'(i) != hit_idx && age_reg[i] < sel_age)
                        begin
                            age_next[i] = age_reg[i] + AGE_W'(1);
                        end
                    end
                    age_next[hit_idx]  = '0;
                    pins_next[hit_idx] = pins_inc;
                    rsp.hit            = 1'b1;
                    rsp.frame_index    = FRAME_W'(hit_idx);
                    rsp.pin_count      = pins_inc;
                end
                else
                begin
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (valid_reg[i] && !(full && IDX_W'(i) == victim_idx))
                        begin
                            age_next[i] = age_reg[i] + AGE_W'(1);
                        end
                    end
                    valid_next[tgt_idx] = 1'b1;
                    age_next[tgt_idx]   = '0;
                    pins_next[tgt_idx]  = PINS_W'(1);
                    dirty_next[tgt_idx] = 1'b0;
                    occ_next            = full ? occ_reg : occ_reg + OCC_W'(1);
                    rsp.frame_index     = FRAME_W'(tgt_idx);
                    rsp.evicted         = full;
                    rsp.evicted_page_id = full ? page_reg[victim_idx] : '0;
                    rsp.pin_count       = PINS_W'(1);
                end
            end
            else if (hit_any)
            begin
                if (req.set_dirty)
                begin
                    dirty_next[hit_idx] = 1'b1;
                end
                pins_next[hit_idx] = pins_dec;
                if (pins_dec == '0)
                begin
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (valid_reg[i] && IDX_W'(i) != hit_idx && age_reg[i] > sel_age)
                        begin
                            age_next[i] = age_reg[i] - AGE_W'(1);
                        end
                    end
                    age_next[hit_idx] = AGE_W'(occ_reg - OCC_W'(1));
                end
                rsp.found       = 1'b1;
                rsp.frame_index = FRAME_W'(hit_idx);
                rsp.pin_count   = pins_dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                valid_reg[i] <= 1'b0;
                age_reg[i]   <= '0;
                pins_reg[i]  <= '0;
                dirty_reg[i] <= 1'b0;
            end
            occ_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                valid_reg[i] <= valid_next[i];
                age_reg[i]   <= age_next[i];
                pins_reg[i]  <= pins_next[i];
                dirty_reg[i] <= dirty_next[i];
            end
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (page_we)
        begin
            page_reg[tgt_idx] <= req.page_id;
        end
    end

endmodule

// ===== rtl/lru_page_buffer_pool_unit.sv =====
// ----------------------------------------------------------------------------
// lru_page_buffer_pool_unit
// LRU page table of a buffer pool: fetch and unpin requests, one result each.
// ----------------------------------------------------------------------------
// channel  | dir | fields
// s_axis   | in  | tuser: action; tdata: page_id[31:0], set_dirty[32]
// m_axis   | out | tdata: hit, found, frame_index, evicted, evicted_page_id,
//          |     |        pin_count (lowest bit up)
// cfg      | in  | cfg_wdata: capacity_in_use
//
// One transaction per cycle sustained while m_tready stays high; an accepted
// request passes the input register, then the table lookup and update into
// the result register, before it shows on m_tvalid.
// The tag compare and age update over all frames happen in the same cycle.
// Reset clears all frames; the block accepts requests right after reset.
// A stalled result holds the table; the input register still takes one more.
// ----------------------------------------------------------------------------
module lru_page_buffer_pool_unit
    import lpb_pkg::*;
#(
    parameter int CAPACITY = CAP_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // page_id, set_dirty
    input  logic                  s_tuser,   // action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // hit, found, frame_index, evicted,
                                             // evicted_page_id, pin_count
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    logic [CFG_W-1:0]      capacity_in_use_reg;
    lpb_req_t              req_in;
    lpb_req_t              req;
    logic                  req_valid;
    logic                  advance;
    lpb_rsp_t              rsp;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;

    assign req_in.action    = s_tuser;
    assign req_in.page_id   = s_tdata[IB_PAGE +: PAGE_W];
    assign req_in.set_dirty = s_tdata[IB_DIRTY];

    assign advance        = req_valid && (!out_valid_reg || m_tready);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    lpb_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .req_in    (req_in),
        .advance   (advance),
        .req_valid (req_valid),
        .req_out   (req)
    );

    lpb_table #(
        .CAPACITY (CAPACITY)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap_cfg   (capacity_in_use_reg),
        .req_valid (advance),
        .req       (req),
        .rsp       (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_in_use_reg <= CFG_RESET;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_in_use_reg <= cfg_wdata;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= pack_rsp(rsp);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/lpb_checker.sv =====
// ----------------------------------------------------------------------------
// lpb_checker
// Port-level checks of the LRU page buffer pool, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpb_checker
    import lpb_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    logic [2:0]        out_kinds;
    logic [PINS_W-1:0] out_pins;

    assign out_kinds = {m_tdata[OB_HIT], m_tdata[OB_FOUND], m_tdata[OB_EVICT]};
    assign out_pins  = m_tdata[OB_PINS +: PINS_W];

    `LPB_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    `LPB_ASSERT(a_kind_excl, clk, rst_n, m_tvalid |-> $countones(out_kinds) <= 1)
    `LPB_ASSERT(a_hit_pinned, clk, rst_n, m_tvalid && m_tdata[OB_HIT] |-> out_pins != '0)
    `LPB_ASSERT(a_in_stall, clk, rst_n, !s_tready |-> m_tvalid && !m_tready)
    `LPB_ASSERT_ALWAYS(a_rst_idle, clk, !rst_n |=> !m_tvalid)

endmodule

bind lru_page_buffer_pool_unit lpb_checker u_lpb_checker (.*);
